>>> src/dfl_pkg.sv
package dfl_pkg;

  // Buffer and delimiter bounds.
  localparam int unsigned MAX_BYTES   = 65536;
  localparam int unsigned MAX_PATTERN = 8;

  localparam int unsigned POS_W   = $clog2(MAX_BYTES);
  localparam int unsigned COUNT_W = POS_W + 1;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned PAT_W   = 8 * MAX_PATTERN;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  // Report modes.
  localparam logic [1:0] MODE_FIND    = 2'd0;
  localparam logic [1:0] MODE_HEADER  = 2'd1;
  localparam logic [1:0] MODE_TRAILER = 2'd2;
  localparam logic [1:0] MODE_ALL     = 2'd3;

  // One reported range.
  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   range_start;
    logic [COUNT_W-1:0] range_end;
    logic               overflow;
  } dfl_result_t;

endpackage

>>> src/dfl_ifs.sv
// Input word channel: one buffer byte and its final-byte flag.
interface dfl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result word channel: one range per buffer.
interface dfl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [dfl_pkg::POS_W-1:0]      range_start;
  logic [dfl_pkg::COUNT_W-1:0]    range_end;
  logic                           overflow;
  modport source (output valid, output found, output range_start, output range_end,
                  output overflow, input ready);
  modport sink   (input valid, input found, input range_start, input range_end,
                  input overflow, output ready);
endinterface

// Configuration write channel.
interface dfl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dfl_pkg::CFG_IDX_W-1:0]     index;
  logic [dfl_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/dfl_cell.sv
// One window cell: holds one byte of the sliding window, passes it on to the
// next older cell on every accepted word, and checks the byte it is taking
// against its delimiter byte.
module dfl_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic       active,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  output logic [7:0] byte_out,
  output logic       match
);

  // Window byte; its contents are gated by the byte count, so no reset.
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_out <= byte_in;
    end
  end

  // A cell beyond the delimiter length always agrees.
  assign match = !active || (byte_in == pat_byte);

endmodule

>>> src/dfl_tracker.sv
// Per-buffer bookkeeping: byte count, first and second match positions and
// the overflow flag. Forms the result for the word being accepted.
module dfl_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        last,
  input  logic                        window_hit,
  input  logic [dfl_pkg::LEN_W-1:0]   len,
  input  logic [1:0]                  mode,
  output dfl_pkg::dfl_result_t        result
);

  logic [dfl_pkg::COUNT_W-1:0] count;
  logic                        first_hit;
  logic [dfl_pkg::POS_W-1:0]   first_position;
  logic                        second_hit;
  logic [dfl_pkg::POS_W-1:0]   second_position;
  logic                        length_overflow;

  logic [dfl_pkg::COUNT_W-1:0] count_next;
  logic                        first_hit_next;
  logic [dfl_pkg::POS_W-1:0]   first_position_next;
  logic                        second_hit_next;
  logic [dfl_pkg::POS_W-1:0]   second_position_next;
  logic                        length_overflow_next;

  logic                        beyond;
  logic [dfl_pkg::COUNT_W-1:0] count_inc;
  logic [dfl_pkg::COUNT_W-1:0] len_ext;
  logic [dfl_pkg::COUNT_W-1:0] pos_wide;
  logic [dfl_pkg::COUNT_W-1:0] second_min;
  logic                        hit;

  // Update for the word being accepted.
  always_comb begin
    beyond    = (count >= dfl_pkg::COUNT_W'(dfl_pkg::MAX_BYTES));
    count_inc = count + dfl_pkg::COUNT_W'(1);
    len_ext   = dfl_pkg::COUNT_W'(len);
    pos_wide  = count_inc - len_ext;
    second_min = dfl_pkg::COUNT_W'(first_position) + len_ext;
    hit = !beyond && (count_inc >= len_ext) && window_hit;

    count_next           = beyond ? count : count_inc;
    length_overflow_next = length_overflow || beyond;
    first_hit_next       = first_hit;
    first_position_next  = first_position;
    second_hit_next      = second_hit;
    second_position_next = second_position;
    if (hit) begin
      if (!first_hit) begin
        first_hit_next      = 1'b1;
        first_position_next = pos_wide[dfl_pkg::POS_W-1:0];
      end else if (!second_hit && (pos_wide >= second_min)) begin
        second_hit_next      = 1'b1;
        second_position_next = pos_wide[dfl_pkg::POS_W-1:0];
      end
    end
  end

  // Result for a final byte, taken from the updated state.
  always_comb begin
    result = '0;
    result.overflow = length_overflow_next;
    unique case (mode)
      dfl_pkg::MODE_FIND: begin
        if (first_hit_next) begin
          result.found       = 1'b1;
          result.range_start = first_position_next;
          result.range_end   = dfl_pkg::COUNT_W'(first_position_next) + len_ext
                               - dfl_pkg::COUNT_W'(1);
        end
      end
      dfl_pkg::MODE_HEADER: begin
        if (first_hit_next) begin
          result.found       = 1'b1;
          result.range_start = first_position_next;
          result.range_end   = second_hit_next
                               ? dfl_pkg::COUNT_W'(second_position_next) - dfl_pkg::COUNT_W'(1)
                               : dfl_pkg::COUNT_W'(first_position_next);
        end
      end
      dfl_pkg::MODE_TRAILER: begin
        if (first_hit_next) begin
          result.found     = 1'b1;
          result.range_end = dfl_pkg::COUNT_W'(first_position_next) + len_ext
                             - dfl_pkg::COUNT_W'(1);
        end
      end
      default: begin
        result.found     = 1'b1;
        result.range_end = count_next;
      end
    endcase
  end

  // State registers; a final byte clears them for the next buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      first_hit       <= 1'b0;
      first_position  <= '0;
      second_hit      <= 1'b0;
      second_position <= '0;
      length_overflow <= 1'b0;
    end else if (step) begin
      if (last) begin
        count           <= '0;
        first_hit       <= 1'b0;
        first_position  <= '0;
        second_hit      <= 1'b0;
        second_position <= '0;
        length_overflow <= 1'b0;
      end else begin
        count           <= count_next;
        first_hit       <= first_hit_next;
        first_position  <= first_position_next;
        second_hit      <= second_hit_next;
        second_position <= second_position_next;
        length_overflow <= length_overflow_next;
      end
    end
  end

endmodule

>>> src/delimiter_frame_locator_top.sv
// Delimiter frame locator.
// A buffer arrives on in_ch one byte per word, last_byte set on its final
// byte. A chain of eight window cells shifts each accepted byte along and
// compares it against the delimiter set through cfg_ch (mode, pattern,
// pattern_length as register indexes 0, 1, 2); cfg_ch is always ready and
// must only be written while no buffer is in progress.
// Nothing is reported for bytes before the final one. The final byte yields
// one result word on out_ch in the cycle after it is accepted: found,
// range_start, range_end and overflow, chosen by the mode.
// Throughput is one byte per clock while no result waits on out_ch;
// the next buffer may start right behind a final byte.
// The result sits in one output register. While it waits for out_ch.ready,
// in_ch stays ready only if the waiting word leaves in the same cycle, so a
// stalled receiver holds the input after one result.
// Reset clears the registers (mode 0, pattern 0, length 1), the byte count,
// the match bookkeeping and the output valid; window bytes are not cleared.
module delimiter_frame_locator_top (
  input  logic           clk,
  input  logic           rst,
  dfl_in_if.sink         in_ch,
  dfl_out_if.source      out_ch,
  dfl_cfg_if.sink        cfg_ch
);

  logic [1:0]                   mode;
  logic [dfl_pkg::PAT_W-1:0]    pattern;
  logic [dfl_pkg::LEN_W-1:0]    pattern_length;
  logic [dfl_pkg::LEN_W-1:0]    len;

  logic                         accept;
  logic [7:0]                   cell_byte [dfl_pkg::MAX_PATTERN];
  logic [7:0]                   cell_in   [dfl_pkg::MAX_PATTERN];
  logic [7:0]                   cell_pat  [dfl_pkg::MAX_PATTERN];
  logic [dfl_pkg::MAX_PATTERN-1:0] cell_active;
  logic [dfl_pkg::MAX_PATTERN-1:0] cell_match;
  logic                         window_hit;

  dfl_pkg::dfl_result_t         result;
  dfl_pkg::dfl_result_t         out_word;
  logic                         out_valid;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= dfl_pkg::MODE_FIND;
      pattern        <= '0;
      pattern_length <= dfl_pkg::LEN_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dfl_pkg::REG_MODE:           mode           <= cfg_ch.data[1:0];
        dfl_pkg::REG_PATTERN:        pattern        <= cfg_ch.data[dfl_pkg::PAT_W-1:0];
        dfl_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_ch.data[dfl_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Delimiter length in use, clamped to 1..MAX_PATTERN.
  always_comb begin
    if (pattern_length == '0) begin
      len = dfl_pkg::LEN_W'(1);
    end else if (pattern_length > dfl_pkg::LEN_W'(dfl_pkg::MAX_PATTERN)) begin
      len = dfl_pkg::LEN_W'(dfl_pkg::MAX_PATTERN);
    end else begin
      len = pattern_length;
    end
  end

  // Cell i holds the byte of age i; it meets delimiter byte len-1-i.
  always_comb begin
    logic [dfl_pkg::LEN_W-1:0] k;
    for (int i = 0; i < dfl_pkg::MAX_PATTERN; i++) begin
      k = len - dfl_pkg::LEN_W'(1) - dfl_pkg::LEN_W'(i);
      cell_active[i] = (dfl_pkg::LEN_W'(i) < len);
      cell_pat[i]    = pattern[8 * k[$clog2(dfl_pkg::MAX_PATTERN)-1:0] +: 8];
      cell_in[i]     = (i == 0) ? in_ch.data_byte : cell_byte[(i == 0) ? 0 : i - 1];
    end
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Row of window cells.
  for (genvar g = 0; g < dfl_pkg::MAX_PATTERN; g++) begin : g_cell
    dfl_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .active   (cell_active[g]),
      .byte_in  (cell_in[g]),
      .pat_byte (cell_pat[g]),
      .byte_out (cell_byte[g]),
      .match    (cell_match[g])
    );
  end

  assign window_hit = &cell_match;

  dfl_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .last       (in_ch.last_byte),
    .window_hit (window_hit),
    .len        (len),
    .mode       (mode),
    .result     (result)
  );

  // Output register.
  assign in_ch.ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_ch.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_byte) begin
      out_word <= result;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.found       = out_word.found;
  assign out_ch.range_start = out_word.range_start;
  assign out_ch.range_end   = out_word.range_end;
  assign out_ch.overflow    = out_word.overflow;

  // A result appears only after a final byte.
  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && in_ch.last_byte))
    else $error("result word without a final byte");

  // A final byte always produces a result word in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.last_byte) |=> out_valid)
    else $error("final byte produced no result");

  // A missing delimiter reports an empty range.
  a_empty_when_not_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.found) |-> (out_word.range_start == '0 && out_word.range_end == '0))
    else $error("range reported without a match");

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [dfl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RESULT_LATENCY = 8;
  localparam int unsigned RANDOM_BYTES   = 1500;
  localparam int unsigned DRAIN_LIMIT    = 20000;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;

  dfl_in_if  in_ch();
  dfl_out_if out_ch();
  dfl_cfg_if cfg_ch();

  delimiter_frame_locator_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the configuration registers.
  logic [1:0]  cfg_mode;
  logic [63:0] cfg_pattern;
  logic [3:0]  cfg_plen;

  // Scan state of the buffer in progress.
  logic [63:0] scan_window;
  int unsigned scan_count;
  bit          first_hit;
  int unsigned first_pos;
  bit          second_hit;
  int unsigned second_pos;
  bit          scan_overflow;

  dfl_pkg::dfl_result_t expected_ranges[$];
  int unsigned failures     = 0;
  bit          source_gaps  = 1'b1;
  bit          sink_gaps    = 1'b1;
  int unsigned hold_request = 0;

  logic [1:0] all_modes[4] = '{dfl_pkg::MODE_FIND, dfl_pkg::MODE_HEADER,
                               dfl_pkg::MODE_TRAILER, dfl_pkg::MODE_ALL};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_scan();
    scan_window   = '0;
    scan_count    = 0;
    first_hit     = 1'b0;
    first_pos     = 0;
    second_hit    = 1'b0;
    second_pos    = 0;
    scan_overflow = 1'b0;
  endfunction

  function automatic int unsigned delimiter_length();
    if (int'(cfg_plen) < 1) return 1;
    if (int'(cfg_plen) > int'(dfl_pkg::MAX_PATTERN)) return dfl_pkg::MAX_PATTERN;
    return int'(cfg_plen);
  endfunction

  // Advance the scan by one accepted byte and queue the range on a final byte.
  function automatic void scan_byte(logic [7:0] b, logic fin);
    int unsigned len;
    logic [63:0] recent;
    logic [63:0] mask;
    int unsigned pos;
    int unsigned span_end;
    dfl_pkg::dfl_result_t r;
    len = delimiter_length();
    if (scan_count >= dfl_pkg::MAX_BYTES) begin
      scan_overflow = 1'b1;
    end else begin
      scan_window = {b, scan_window[63:8]};
      scan_count++;
      if (scan_count >= len) begin
        recent = scan_window >> (64 - 8 * len);
        mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        if (recent == (cfg_pattern & mask)) begin
          pos = scan_count - len;
          if (!first_hit) begin
            first_hit = 1'b1;
            first_pos = pos;
          end else if (!second_hit && pos >= first_pos + len) begin
            second_hit = 1'b1;
            second_pos = pos;
          end
        end
      end
    end
    if (fin) begin
      r = '0;
      span_end = 0;
      case (cfg_mode)
        dfl_pkg::MODE_FIND, dfl_pkg::MODE_TRAILER: begin
          if (first_hit) begin
            r.found = 1'b1;
            r.range_start = (cfg_mode == dfl_pkg::MODE_FIND) ?
                            dfl_pkg::POS_W'(first_pos) : '0;
            span_end = first_pos + len - 1;
          end
        end
        dfl_pkg::MODE_HEADER: begin
          if (first_hit) begin
            r.found = 1'b1;
            r.range_start = dfl_pkg::POS_W'(first_pos);
            span_end = second_hit ? second_pos - 1 : first_pos;
          end
        end
        default: begin
          r.found = 1'b1;
          span_end = scan_count;
        end
      endcase
      r.range_end = dfl_pkg::COUNT_W'(span_end);
      r.overflow = scan_overflow;
      expected_ranges.push_back(r);
      clear_scan();
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, logic [dfl_pkg::COUNT_W-1:0] want,
                                      logic [dfl_pkg::COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: range word %s mismatch, expected %0d, actual %0d",
               $time, name, want, got);
      failures++;
    end
  endfunction

  // Each accepted result word is checked against the oldest expected range.
  always @(posedge clk) begin : range_check
    dfl_pkg::dfl_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_ranges.size() == 0) begin
        $display("%0t: unexpected range word, expected none, actual %0d %0d %0d %0d",
                 $time, out_ch.found, out_ch.range_start, out_ch.range_end,
                 out_ch.overflow);
        failures++;
      end else begin
        want = expected_ranges.pop_front();
        check_field("found", dfl_pkg::COUNT_W'(want.found),
                    dfl_pkg::COUNT_W'(out_ch.found));
        check_field("range_start", dfl_pkg::COUNT_W'(want.range_start),
                    dfl_pkg::COUNT_W'(out_ch.range_start));
        check_field("range_end", want.range_end, out_ch.range_end);
        check_field("overflow", dfl_pkg::COUNT_W'(want.overflow),
                    dfl_pkg::COUNT_W'(out_ch.overflow));
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        out_ch.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 99) < 20) begin
        out_ch.ready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one byte word, possibly after a gap, and predict on acceptance.
  task automatic send_byte(logic [7:0] b, logic fin);
    if (source_gaps && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    scan_byte(b, fin);
  endtask

  task automatic send_buffer(byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Stop offering, wait for every expected range, then let the block settle.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_ranges.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_ranges.size() != 0) begin
      $display("%0t: %0d expected range words, actual none arrived",
               $time, expected_ranges.size());
      failures++;
      expected_ranges.delete();
    end
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [dfl_pkg::CFG_IDX_W-1:0] idx,
                           logic [dfl_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      dfl_pkg::REG_MODE:           cfg_mode = value[1:0];
      dfl_pkg::REG_PATTERN:        cfg_pattern = value;
      dfl_pkg::REG_PATTERN_LENGTH: cfg_plen = value[3:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper bits of mode and length carry random junk.
  task automatic configure(logic [1:0] m, logic [63:0] p, logic [3:0] len);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(dfl_pkg::REG_MODE, {junk[63:2], m});
    write_reg(dfl_pkg::REG_PATTERN, p);
    write_reg(dfl_pkg::REG_PATTERN_LENGTH, {junk[63:4], len});
  endtask

  // Random content with whole delimiters, broken prefixes and loose bytes.
  function automatic byte_q_t make_buffer(int unsigned target);
    byte_q_t q;
    int unsigned len;
    int unsigned take;
    int unsigned pick;
    len = delimiter_length();
    while (q.size() < target) begin
      pick = $urandom_range(0, 99);
      take = (pick < 25) ? len : (pick < 40) ? $urandom_range(1, len) : 0;
      if (take != 0) begin
        for (int i = 0; i < take; i++) q.push_back(cfg_pattern[8 * i +: 8]);
      end else if ($urandom_range(0, 1) == 0) begin
        q.push_back(8'($urandom));
      end else begin
        pick = $urandom_range(0, len - 1);
        q.push_back(cfg_pattern[8 * pick +: 8]);
      end
    end
    return q;
  endfunction

  // Registers still hold their reset values: one zero byte, find mode.
  task automatic test_reset_defaults();
    send_buffer('{8'h11, 8'h00});
    send_buffer('{8'hFF});
    drain();
  endtask

  task automatic test_directed_cases();
    // Length above the bound acts as eight; the match ends on the final byte.
    configure(dfl_pkg::MODE_FIND, 64'h0123_4567_89AB_CDEF, 4'd15);
    send_buffer('{8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h67, 8'h45, 8'h23, 8'h01});
    // A buffer shorter than the delimiter never matches.
    send_buffer('{8'hEF, 8'hCD, 8'hAB});
    drain();
    // Length zero acts as one; headers at 0 and 2.
    configure(dfl_pkg::MODE_HEADER, 64'hFFFF_FFFF_FFFF_FFA5, 4'd0);
    send_buffer('{8'hA5, 8'h00, 8'hA5, 8'hA5});
    drain();
    // Overlapping headers do not count, so the span collapses to one index.
    configure(dfl_pkg::MODE_HEADER, 64'hAAAA, 4'd2);
    send_buffer('{8'hAA, 8'hAA, 8'hAA});
    drain();
    // Trailer mode; a write to the unused index must leave the setup alone.
    configure(dfl_pkg::MODE_TRAILER, 64'h0D0A, 4'd2);
    write_reg(REG_UNUSED, '1);
    send_buffer('{8'h33, 8'h0A, 8'h0D, 8'h44});
    drain();
    configure(dfl_pkg::MODE_ALL, '0, 4'd8);
    send_buffer('{8'hFF});
    drain();
  endtask

  task automatic test_random_buffers();
    int unsigned sent;
    int unsigned phase;
    int unsigned size;
    byte_q_t q;
    logic [1:0] m;
    logic [63:0] p;
    logic [3:0] len;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      // The first phases pin the register extremes, the rest are random.
      case (phase)
        0: begin
          m = dfl_pkg::MODE_HEADER;
          p = '1;
          len = 4'd8;
        end
        1: begin
          m = dfl_pkg::MODE_TRAILER;
          p = '0;
          len = 4'd1;
        end
        2: begin
          m = dfl_pkg::MODE_FIND;
          p = {$urandom, $urandom};
          len = 4'd15;
        end
        3: begin
          m = dfl_pkg::MODE_ALL;
          p = {$urandom, $urandom};
          len = 4'd0;
        end
        default: begin
          m = all_modes[$urandom_range(0, 3)];
          p = {$urandom, $urandom};
          len = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        end
      endcase
      configure(m, p, len);
      source_gaps = (phase % 5 != 4);
      sink_gaps = (phase % 7 != 6);
      repeat ($urandom_range(3, 10)) begin
        size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 120);
        q = make_buffer(size);
        send_buffer(q);
        sent += q.size();
      end
      drain();
      phase++;
    end
    source_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // The receiver holds off while short buffers keep coming, so the input stalls.
  task automatic test_result_stall();
    configure(dfl_pkg::MODE_FIND, 64'h5A, 4'd1);
    source_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_request = 64;
    repeat (40) send_buffer('{8'($urandom), 8'h5A});
    drain();
    source_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin : stimulus
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= dfl_pkg::REG_MODE;
    cfg_ch.data     <= '0;
    cfg_mode    = dfl_pkg::MODE_FIND;
    cfg_pattern = '0;
    cfg_plen    = 4'd1;
    clear_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_random_buffers();
    test_result_stall();

    if (failures == 0) begin
      $display("delimiter_frame_locator_top verification clean");
    end else begin
      $display("delimiter_frame_locator_top verification failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : run_limit
    #20_000_000;
    $display("delimiter_frame_locator_top verification failed");
    $finish;
  end

endmodule
